/* rtl/core/mtep_pkg.sv */
package mtep_pkg;

  // Width of the delta accumulator and absolute time.
  localparam int unsigned TimeBits = 32;
  localparam int unsigned OutTimeBits = 32;

  localparam logic [7:0] DataMask   = 8'h7F;
  localparam logic [7:0] StatusBit  = 8'h80;
  localparam logic [7:0] SysBase    = 8'hF0;
  localparam logic [7:0] SysexStart = 8'hF0;
  localparam logic [7:0] SysexCont  = 8'hF7;
  localparam logic [7:0] MetaStatus = 8'hFF;
  localparam logic [7:0] ProgChange = 8'hC0;
  localparam logic [7:0] ChanPress  = 8'hD0;
  localparam logic [7:0] SongPos    = 8'hF2;
  localparam logic [7:0] TimeCode   = 8'hF1;
  localparam logic [7:0] SongSel    = 8'hF3;

  typedef enum logic [2:0] {
    PH_DELTA    = 3'd0,
    PH_STATUS   = 3'd1,
    PH_DATA1    = 3'd2,
    PH_DATA2    = 3'd3,
    PH_METATYPE = 3'd4,
    PH_LENGTH   = 3'd5,
    PH_PAYLOAD  = 3'd6
  } mtep_phase_e;

  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } mtep_kind_e;

  typedef struct packed {
    mtep_kind_e              kind;
    logic [OutTimeBits-1:0]  event_time;
    logic [7:0]              status_byte;
    logic [7:0]              meta_type;
    logic [1:0]              data_count;
    logic [7:0]              first_data;
    logic [7:0]              second_data;
    logic [31:0]             payload_length;
    logic [7:0]              payload_value;
    logic                    event_done;
  } mtep_result_t;

  // Inline data bytes that follow a status byte.
  function automatic logic [1:0] data_needed(input logic [7:0] st);
    logic [7:0] hi;
    logic [1:0] n;
    hi = st & SysBase;
    if (hi != SysBase) begin
      n = ((hi == ProgChange) || (hi == ChanPress)) ? 2'd1 : 2'd2;
    end else if (st == SongPos) begin
      n = 2'd2;
    end else if ((st == TimeCode) || (st == SongSel)) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

/* rtl/core/mtep_in_reg.sv */
module mtep_in_reg import mtep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] track_byte_i,
  input  logic       last_in_chunk_i,
  input  logic       advance_i,
  output logic       s1_valid_o,
  output logic [7:0] s1_byte_o,
  output logic       s1_last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= track_byte_i;
      last_q <= last_in_chunk_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;
  assign s1_last_o  = last_q;

endmodule

/* rtl/core/mtep_parse.sv */
module mtep_parse import mtep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output logic         res_valid_o,
  output mtep_result_t res_o
);

  mtep_phase_e         phase_q, phase_d;
  logic [TimeBits-1:0] delta_q, delta_d;
  logic [TimeBits-1:0] abs_q, abs_d;
  logic [7:0]          rs_q, rs_d;
  logic [7:0]          held_q, held_d;
  logic [7:0]          meta_q, meta_d;
  logic [31:0]         remain_q, remain_d;

  logic [TimeBits-1:0] delta_sh;
  logic [31:0]         len_sh;
  logic [31:0]         remain_dec;
  logic [1:0]          need_rs;
  logic                emit;
  mtep_kind_e          e_kind;
  logic [1:0]          e_cnt;
  logic [7:0]          e_d1, e_d2, e_pval;
  logic [31:0]         e_plen;
  logic                e_done;
  logic                finish;
  logic                take_data;

  assign delta_sh   = {delta_q[TimeBits-8:0], byte_i[6:0]};
  assign len_sh     = {remain_q[24:0], byte_i[6:0]};
  assign remain_dec = remain_q - 32'd1;
  assign need_rs    = data_needed(rs_q);

  always_comb begin
    phase_d   = phase_q;
    delta_d   = delta_q;
    abs_d     = abs_q;
    rs_d      = rs_q;
    held_d    = held_q;
    meta_d    = meta_q;
    remain_d  = remain_q;
    emit      = 1'b0;
    e_kind    = KIND_SHORT;
    e_cnt     = 2'd0;
    e_d1      = 8'd0;
    e_d2      = 8'd0;
    e_plen    = 32'd0;
    e_pval    = 8'd0;
    e_done    = 1'b0;
    finish    = 1'b0;
    take_data = 1'b0;

    unique case (phase_q)
      PH_STATUS: begin
        if ((byte_i & StatusBit) == 8'd0) begin
          if (rs_q == 8'd0) begin
            abs_d = abs_q + TimeBits'(byte_i);  // stray data byte: more delta time
          end else begin
            take_data = 1'b1;
          end
        end else begin
          rs_d   = byte_i;
          meta_d = 8'd0;
          if (byte_i == MetaStatus) begin
            phase_d = PH_METATYPE;
          end else if ((byte_i == SysexStart) || (byte_i == SysexCont)) begin
            remain_d = 32'd0;
            phase_d  = PH_LENGTH;
          end else if (data_needed(byte_i) == 2'd0) begin
            emit   = 1'b1;
            e_done = 1'b1;
            finish = 1'b1;
          end else begin
            phase_d = PH_DATA1;
          end
        end
      end
      PH_DATA1, PH_DATA2: take_data = 1'b1;
      PH_METATYPE: begin
        meta_d   = byte_i;
        remain_d = 32'd0;
        phase_d  = PH_LENGTH;
      end
      PH_LENGTH: begin
        remain_d = len_sh;
        if (!byte_i[7]) begin
          emit   = 1'b1;
          e_kind = KIND_HEADER;
          e_plen = len_sh;
          e_done = (len_sh == 32'd0);
          if (len_sh == 32'd0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        remain_d = remain_dec;
        emit     = 1'b1;
        e_kind   = KIND_PAYLOAD;
        e_pval   = byte_i;
        e_done   = (remain_dec == 32'd0);
        finish   = (remain_dec == 32'd0);
      end
      default: begin
        delta_d = delta_sh;
        if (!byte_i[7]) begin
          abs_d   = abs_q + delta_sh;
          delta_d = '0;
          phase_d = PH_STATUS;
        end else begin
          phase_d = PH_DELTA;
        end
      end
    endcase

    if (take_data) begin
      if (phase_q == PH_DATA2) begin
        emit   = 1'b1;
        e_cnt  = 2'd2;
        e_d1   = held_q;
        e_d2   = byte_i;
        e_done = 1'b1;
        finish = 1'b1;
      end else if (need_rs == 2'd1) begin
        emit   = 1'b1;
        e_cnt  = 2'd1;
        e_d1   = byte_i;
        e_done = 1'b1;
        finish = 1'b1;
      end else begin
        held_d  = byte_i;
        phase_d = PH_DATA2;
      end
    end

    res_o.kind           = e_kind;
    res_o.event_time     = OutTimeBits'(abs_d);
    res_o.status_byte    = rs_d;
    res_o.meta_type      = meta_d;
    res_o.data_count     = e_cnt;
    res_o.first_data     = e_d1;
    res_o.second_data    = e_d2;
    res_o.payload_length = e_plen;
    res_o.payload_value  = e_pval;
    res_o.event_done     = e_done;

    // system messages cancel running status
    if (finish) begin
      if (rs_d >= SysBase) begin
        rs_d = 8'd0;
      end
      meta_d  = 8'd0;
      held_d  = 8'd0;
      phase_d = PH_DELTA;
    end

    if (last_i) begin
      phase_d  = PH_DELTA;
      delta_d  = '0;
      abs_d    = '0;
      rs_d     = 8'd0;
      held_d   = 8'd0;
      meta_d   = 8'd0;
      remain_d = 32'd0;
    end
  end

  assign res_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      delta_q  <= '0;
      abs_q    <= '0;
      rs_q     <= 8'd0;
      held_q   <= 8'd0;
      meta_q   <= 8'd0;
      remain_q <= 32'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      abs_q    <= abs_d;
      rs_q     <= rs_d;
      held_q   <= held_d;
      meta_q   <= meta_d;
      remain_q <= remain_d;
    end
  end

  a_short_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_SHORT) |-> res_o.event_done)
    else $error("short event without done");

  a_chunk_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> (phase_q == PH_DELTA) && (rs_q == 8'd0) && (abs_q == '0))
    else $error("state not cleared after chunk end");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (remain_q != 32'd0))
    else $error("payload phase with no bytes left");

  a_long_no_inline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != KIND_SHORT) |-> (res_o.data_count == 2'd0))
    else $error("long event item carries inline data");

endmodule

/* rtl/core/mtep_out_reg.sv */
module mtep_out_reg import mtep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  input  mtep_result_t res_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mtep_result_t out_o
);

  logic         valid_q;
  mtep_result_t data_q;

  // register can load when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

/* rtl/core/midi_track_event_parser.sv */
// A result is offered once its byte has passed the input register at the transfer edge and then
//   the parse logic into the result register, which loads only while it can take a value.
// Throughput: one byte per cycle while the result register can take a value, set by the single state update per byte.
// Bytes that produce no result still take a step in the parse stage and need the result register free.
// Reset (rst_ni low, asynchronous) clears the parse state, time and both stages.
module midi_track_event_parser import mtep_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             track_byte_i,
  input  logic                   last_in_chunk_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             item_kind_o,
  output logic [OutTimeBits-1:0] event_time_o,
  output logic [7:0]             status_byte_o,
  output logic [7:0]             meta_type_o,
  output logic [1:0]             data_count_o,
  output logic [7:0]             first_data_o,
  output logic [7:0]             second_data_o,
  output logic [31:0]            payload_length_o,
  output logic [7:0]             payload_value_o,
  output logic                   event_done_o
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         out_free;
  logic         step;
  logic         res_valid;
  mtep_result_t res;
  mtep_result_t out_res;

  // The parse stage advances whenever a byte is held and the result register can take a value,
  // whether or not this byte produces a result.
  assign step = s1_valid && out_free;

  mtep_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .track_byte_i,
    .last_in_chunk_i,
    .advance_i  (out_free),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte),
    .s1_last_o  (s1_last)
  );

  // Delta decode, running status, long event length/payload tracking.
  mtep_parse u_parse (
    .clk_i,
    .rst_ni,
    .step_i      (step),
    .byte_i      (s1_byte),
    .last_i      (s1_last),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_reg u_out_reg (
    .clk_i,
    .rst_ni,
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o,
    .out_ready_i,
    .out_o       (out_res)
  );

  assign item_kind_o      = out_res.kind;
  assign event_time_o     = out_res.event_time;
  assign status_byte_o    = out_res.status_byte;
  assign meta_type_o      = out_res.meta_type;
  assign data_count_o     = out_res.data_count;
  assign first_data_o     = out_res.first_data;
  assign second_data_o    = out_res.second_data;
  assign payload_length_o = out_res.payload_length;
  assign payload_value_o  = out_res.payload_value;
  assign event_done_o     = out_res.event_done;

endmodule
